### rtl/qvr_pkg.sv
// ---------------------------------------------------------------------------
// qvr_pkg: shared types and helpers for the quaternion vector rotator.
// Holds the fixed-point formats and pipeline depths that the top level and
// the normalizer both use, and the rounding functions of the top level.
// ---------------------------------------------------------------------------
package qvr_pkg;

	// Field formats.
	localparam int COORD_W    = 24;  // coordinate width, Q.12
	localparam int COORD_FRAC = 12;
	localparam int QUAT_W     = 16;  // quaternion component width, Q1.14
	localparam int QUAT_FRAC  = 14;
	localparam int UNIT_FRAC  = 30;  // unit vectors are Q1.30
	localparam int R_FRAC     = UNIT_FRAC + QUAT_FRAC;

	// Normalizer formats.
	localparam int NORM_W    = 52;                 // holds a difference or a rotated vector
	localparam int P_W       = $clog2(NORM_W);     // leading-one position
	localparam int SHIFT_W   = 7;                  // signed scale exponent
	localparam int A_W       = UNIT_FRAC + 1;      // scaled magnitude
	localparam int SUM_W     = 64;                 // sum of squares
	localparam int LEN_W     = 32;                 // integer root
	localparam int UNIT_W    = UNIT_FRAC + 2;      // signed unit component
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int DIV_STEPS  = UNIT_FRAC + 1;
	localparam int DIV_N_W    = A_W + UNIT_FRAC + 1;

	// Pipeline depths.
	localparam int NORM_LAT = 5 + 1 + SQRT_STEPS + 1 + DIV_STEPS + 1;
	localparam int ROT_LAT  = 6;
	localparam int FIN_LAT  = 3;
	localparam int PIPE_LAT = 1 + NORM_LAT + ROT_LAT + NORM_LAT + FIN_LAT;

	// Configuration register indexes.
	localparam logic [1:0] REG_QUAT_X = 2'd0;
	localparam logic [1:0] REG_QUAT_Y = 2'd1;
	localparam logic [1:0] REG_QUAT_Z = 2'd2;
	localparam logic [1:0] REG_QUAT_W = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [QUAT_W-1:0]  quat_t;
	typedef logic signed [NORM_W-1:0]  nvec_t;
	typedef logic signed [UNIT_W-1:0]  unit_t;

	// Data that rides alongside a vector through a normalizer.
	typedef struct packed {
		logic                       about;
		coord_t [2:0]               cen;
		logic [LEN_W-1:0]           len;
		logic signed [SHIFT_W-1:0]  sh;
	} side_t;

	// Normalizer result.
	typedef struct packed {
		logic                       nz;
		unit_t [2:0]                u;
		logic [LEN_W-1:0]           len;
		logic signed [SHIFT_W-1:0]  sh;
	} nres_t;

	// Shift right by n with rounding to nearest, half away from zero.
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
		input int unsigned n);
		logic [63:0] mag;
		logic [63:0] half;
		half = 64'd1 << (n - 1);
		mag  = v[63] ? (~v + 64'd1) : v;
		mag  = (mag + half) >> n;
		return v[63] ? $signed(~mag + 64'd1) : $signed(mag);
	endfunction

	// Saturate to the coordinate range.
	function automatic coord_t sat_coord(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = {{(64-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return COORD_W'(hi);
		end else if (v < lo) begin
			return COORD_W'(lo);
		end
		return COORD_W'(v);
	endfunction

endpackage

### rtl/qvr_norm.sv
// ---------------------------------------------------------------------------
// qvr_norm: pipelined 3-D vector normalizer.
// Scales the magnitudes so the largest sits in [2^30, 2^31), takes the
// integer square root of the sum of squares one result bit per stage, then
// divides each component by that length one quotient bit per stage.
// ---------------------------------------------------------------------------
module qvr_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  qvr_pkg::nvec_t [2:0] in_vec,
	input  qvr_pkg::side_t    in_side,
	output logic              out_valid,
	output qvr_pkg::nres_t    out_res,
	output qvr_pkg::side_t    out_side
);
	import qvr_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0]           rem;
		logic [SUM_W-1:0]           root;
		logic [2:0][A_W-1:0]        a;
		logic [2:0]                 neg;
		logic                       nz;
		logic signed [SHIFT_W-1:0]  sh;
		side_t                      side;
	} sqst_t;

	typedef struct packed {
		logic [2:0][DIV_N_W-1:0]    n;
		logic [2:0][LEN_W-1:0]      r;
		logic [2:0][DIV_STEPS-1:0]  q;
		logic [LEN_W-1:0]           len;
		logic [2:0]                 neg;
		logic                       nz;
		logic signed [SHIFT_W-1:0]  sh;
		side_t                      side;
	} dvst_t;

	localparam logic [DIV_STEPS-1:0] UNIT_ONE = DIV_STEPS'(1) << UNIT_FRAC;

	// Front stages.
	logic                       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][NORM_W-1:0]     m_s1, m_s2, m_s3;
	logic [2:0]                 neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	side_t                      side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [NORM_W-1:0]          mx_s2;
	logic [P_W-1:0]             p_s3;
	logic                       nz_s3, nz_s4, nz_s5;
	logic [2:0][A_W-1:0]        a_s4, a_s5;
	logic signed [SHIFT_W-1:0]  sh_s4, sh_s5;
	logic [2:0][2*A_W-1:0]      sq_s5;

	logic [NORM_W-1:0]          mx_c;
	logic [P_W-1:0]             p_c;
	logic [2:0][A_W-1:0]        a_c;

	sqst_t                      sq_s [SQRT_STEPS+1];
	logic                       sq_v [SQRT_STEPS+1];
	dvst_t                      dv_s [DIV_STEPS+1];
	logic                       dv_v [DIV_STEPS+1];
	dvst_t                      dv0_c;
	nres_t                      res_c;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Largest magnitude and its leading one.
	always_comb begin
		mx_c = m_s1[0];
		if (m_s1[1] > mx_c) begin
			mx_c = m_s1[1];
		end
		if (m_s1[2] > mx_c) begin
			mx_c = m_s1[2];
		end
	end

	always_comb begin
		p_c = '0;
		for (int i = 0; i < NORM_W; i++) begin
			if (mx_s2[i]) begin
				p_c = P_W'(i);
			end
		end
	end

	// Scale the magnitudes so the largest lands in [2^30, 2^31).
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (p_s3 >= P_W'(UNIT_FRAC)) begin
				a_c[i] = A_W'(m_s3[i] >> (p_s3 - P_W'(UNIT_FRAC)));
			end else begin
				a_c[i] = A_W'(m_s3[i] << (P_W'(UNIT_FRAC) - p_s3));
			end
		end
	end

	// Front stage payload.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= in_vec[i][NORM_W-1];
			m_s1[i]   <= in_vec[i][NORM_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
		end
		side_s1 <= in_side;

		m_s2    <= m_s1;
		neg_s2  <= neg_s1;
		mx_s2   <= mx_c;
		side_s2 <= side_s1;

		m_s3    <= m_s2;
		neg_s3  <= neg_s2;
		p_s3    <= p_c;
		nz_s3   <= (mx_s2 != '0);
		side_s3 <= side_s2;

		a_s4    <= a_c;
		sh_s4   <= $signed(SHIFT_W'(p_s3)) - $signed(SHIFT_W'(UNIT_FRAC));
		nz_s4   <= nz_s3;
		neg_s4  <= neg_s3;
		side_s4 <= side_s3;

		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= a_s4[i] * a_s4[i];
		end
		a_s5    <= a_s4;
		sh_s5   <= sh_s4;
		nz_s5   <= nz_s4;
		neg_s5  <= neg_s4;
		side_s5 <= side_s4;
	end

	// Sum of squares opens the root pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else begin
			sq_v[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sq_s[0].rem  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
		sq_s[0].root <= '0;
		sq_s[0].a    <= a_s5;
		sq_s[0].neg  <= neg_s5;
		sq_s[0].nz   <= nz_s5;
		sq_s[0].sh   <= sh_s5;
		sq_s[0].side <= side_s5;
	end

	// Integer square root, one result bit per stage.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SUM_W-1:0] SQ_BIT = SUM_W'(1) << (SUM_W - 2 - 2*k);
		logic [SUM_W-1:0] trial;
		sqst_t            nxt;

		always_comb begin
			nxt   = sq_s[k];
			trial = sq_s[k].root + SQ_BIT;
			if (sq_s[k].rem >= trial) begin
				nxt.rem  = sq_s[k].rem - trial;
				nxt.root = (sq_s[k].root >> 1) + SQ_BIT;
			end else begin
				nxt.root = sq_s[k].root >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_s[k+1] <= nxt;
		end
	end

	// Dividends with the half-divisor rounding term.
	always_comb begin
		dv0_c     = '0;
		dv0_c.len = sq_s[SQRT_STEPS].root[LEN_W-1:0];
		for (int i = 0; i < 3; i++) begin
			dv0_c.n[i] = (DIV_N_W'(sq_s[SQRT_STEPS].a[i]) << UNIT_FRAC)
				+ DIV_N_W'(sq_s[SQRT_STEPS].root[LEN_W-1:1]);
			dv0_c.r[i] = LEN_W'(dv0_c.n[i] >> DIV_STEPS);
		end
		dv0_c.neg  = sq_s[SQRT_STEPS].neg;
		dv0_c.nz   = sq_s[SQRT_STEPS].nz;
		dv0_c.sh   = sq_s[SQRT_STEPS].sh;
		dv0_c.side = sq_s[SQRT_STEPS].side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else begin
			dv_v[0] <= sq_v[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		dv_s[0] <= dv0_c;
	end

	// Restoring division of the three components, one quotient bit per stage.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int J = DIV_STEPS - 1 - k;
		logic [LEN_W:0] rt;
		dvst_t          nxt;

		always_comb begin
			nxt = dv_s[k];
			rt  = '0;
			for (int i = 0; i < 3; i++) begin
				rt = {dv_s[k].r[i], dv_s[k].n[i][J]};
				if (rt >= {1'b0, dv_s[k].len}) begin
					rt           = rt - {1'b0, dv_s[k].len};
					nxt.q[i][J]  = 1'b1;
				end
				nxt.r[i] = rt[LEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_s[k+1] <= nxt;
		end
	end

	// Cap at one, restore signs; a zero vector gives zeros.
	always_comb begin
		logic [DIV_STEPS-1:0] qv;
		res_c     = '0;
		res_c.nz  = dv_s[DIV_STEPS].nz;
		for (int i = 0; i < 3; i++) begin
			qv = dv_s[DIV_STEPS].q[i];
			if (qv > UNIT_ONE) begin
				qv = UNIT_ONE;
			end
			res_c.u[i] = dv_s[DIV_STEPS].neg[i] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
		end
		res_c.len = dv_s[DIV_STEPS].len;
		res_c.sh  = dv_s[DIV_STEPS].sh;
		if (!dv_s[DIV_STEPS].nz) begin
			res_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= dv_v[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		out_res  <= res_c;
		out_side <= dv_s[DIV_STEPS].side;
	end

	// Checks.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##NORM_LAT out_valid)
		else $error("normalizer lost a request");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && (in_vec == '0) |-> ##NORM_LAT !out_res.nz)
		else $error("zero vector reported as nonzero");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.nz |-> (out_res.len[LEN_W-1:UNIT_FRAC] != '0))
		else $error("length of a scaled vector below 2^30");

endmodule

### rtl/quaternion_vector_rotate.sv
// ---------------------------------------------------------------------------
// quaternion_vector_rotate: rotates a 3-D vector by a configured quaternion.
// Direction mode returns the rotated unit vector; about-center mode rotates
// a point about a center and keeps its distance to the center.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ---------------------------------------
//  request   start, busy            vec_x/y/z, center_x/y/z, about_center
//  result    done (one-cycle pulse) res_x, res_y, res_z
//  config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A request is taken in every cycle; busy never rises.
// Each result passes through an input stage, a first normalizer, six
// rotation stages, a second normalizer and three output stages; each
// normalizer has 71 stages (32 square-root and 31 divide stages).
// Reset clears the valid bits and loads the identity quaternion.
// The pipeline never stalls; results leave in request order.
//
module quaternion_vector_rotate (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  qvr_pkg::coord_t vec_x,
	input  qvr_pkg::coord_t vec_y,
	input  qvr_pkg::coord_t vec_z,
	input  qvr_pkg::coord_t center_x,
	input  qvr_pkg::coord_t center_y,
	input  qvr_pkg::coord_t center_z,
	input  logic            about_center,
	output logic            done,
	output qvr_pkg::coord_t res_x,
	output qvr_pkg::coord_t res_y,
	output qvr_pkg::coord_t res_z,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  qvr_pkg::quat_t  cfg_data
);
	import qvr_pkg::*;

	localparam int D_W  = COORD_W + 1;
	localparam int PU_W = UNIT_W + QUAT_W;
	localparam int TS_W = PU_W + 2;
	localparam int T_W  = TS_W - QUAT_FRAC;
	localparam int PO_W = T_W + QUAT_W;
	localparam int MAG_W = UNIT_FRAC + 1;

	logic  acc;
	quat_t qx_q, qy_q, qz_q, qw_q;

	// Stage registers (normalizer stages are internal to qvr_norm).
	logic   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	coord_t p_s1 [3];
	coord_t c_s1 [3];
	logic   about_s1;
	logic signed [PU_W-1:0] pt_s2 [4][3];
	logic signed [TS_W-1:0] ts_s3 [4];
	logic signed [T_W-1:0]  t_s4 [4];
	logic signed [PO_W-1:0] po_s5 [3][4];
	nvec_t  r_s6 [3];
	side_t  side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;
	nvec_t [2:0] r_s7;
	logic [2*LEN_W-2:0] prod_s8 [3];
	logic [2:0]   neg_s8, neg_s9;
	logic         nz_s8, nz_s9;
	logic [63:0]  off_s9 [3];
	coord_t       res_s10 [3];

	nvec_t [2:0] n1_vec;
	side_t       n1_side_in;
	logic        n1_v, n2_v;
	nres_t       n1_res, n2_res;
	side_t       n1_side, n2_side;
	side_t       side2_c;
	side_t       side7_c;
	logic [SHIFT_W-1:0] shr_c;

	assign acc       = start && !busy;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Quaternion registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
			qw_q <= QUAT_W'(1) <<< QUAT_FRAC;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_QUAT_X: qx_q <= cfg_data;
				REG_QUAT_Y: qy_q <= cfg_data;
				REG_QUAT_Z: qz_q <= cfg_data;
				REG_QUAT_W: qw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits of the top-level stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s1  <= acc;
			v_s2  <= n1_v;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= n2_v;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		p_s1[0]  <= vec_x;
		p_s1[1]  <= vec_y;
		p_s1[2]  <= vec_z;
		c_s1[0]  <= center_x;
		c_s1[1]  <= center_y;
		c_s1[2]  <= center_z;
		about_s1 <= about_center;
	end

	// Direction to normalize: the vector itself, or center minus point.
	always_comb begin
		logic signed [D_W-1:0] d;
		n1_side_in       = '0;
		n1_side_in.about = about_s1;
		for (int i = 0; i < 3; i++) begin
			d = D_W'(c_s1[i]) - D_W'(p_s1[i]);
			n1_vec[i] = about_s1 ? NORM_W'(d) : NORM_W'(p_s1[i]);
			n1_side_in.cen[i] = c_s1[i];
		end
	end

	qvr_norm u_norm1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_vec    (n1_vec),
		.in_side   (n1_side_in),
		.out_valid (n1_v),
		.out_res   (n1_res),
		.out_side  (n1_side)
	);

	// The first normalizer's length and shift join the side data.
	always_comb begin
		side2_c     = n1_side;
		side2_c.len = n1_res.len;
		side2_c.sh  = n1_res.sh;
	end

	// Rotation t = u * conj(q), then r = q * t.
	always_ff @(posedge clk) begin
		pt_s2[0][0] <= $signed(n1_res.u[0]) * qw_q;
		pt_s2[0][1] <= $signed(n1_res.u[1]) * qz_q;
		pt_s2[0][2] <= $signed(n1_res.u[2]) * qy_q;
		pt_s2[1][0] <= $signed(n1_res.u[0]) * qz_q;
		pt_s2[1][1] <= $signed(n1_res.u[1]) * qw_q;
		pt_s2[1][2] <= $signed(n1_res.u[2]) * qx_q;
		pt_s2[2][0] <= $signed(n1_res.u[0]) * qy_q;
		pt_s2[2][1] <= $signed(n1_res.u[1]) * qx_q;
		pt_s2[2][2] <= $signed(n1_res.u[2]) * qw_q;
		pt_s2[3][0] <= $signed(n1_res.u[0]) * qx_q;
		pt_s2[3][1] <= $signed(n1_res.u[1]) * qy_q;
		pt_s2[3][2] <= $signed(n1_res.u[2]) * qz_q;
		side_s2     <= side2_c;

		ts_s3[0] <= TS_W'(pt_s2[0][0]) - TS_W'(pt_s2[0][1]) + TS_W'(pt_s2[0][2]);
		ts_s3[1] <= TS_W'(pt_s2[1][0]) + TS_W'(pt_s2[1][1]) - TS_W'(pt_s2[1][2]);
		ts_s3[2] <= TS_W'(pt_s2[2][1]) + TS_W'(pt_s2[2][2]) - TS_W'(pt_s2[2][0]);
		ts_s3[3] <= TS_W'(pt_s2[3][0]) + TS_W'(pt_s2[3][1]) + TS_W'(pt_s2[3][2]);
		side_s3  <= side_s2;

		for (int i = 0; i < 4; i++) begin
			t_s4[i] <= T_W'(rnd_shr(64'(ts_s3[i]), QUAT_FRAC));
		end
		side_s4 <= side_s3;

		po_s5[0][0] <= qw_q * t_s4[0];
		po_s5[0][1] <= qx_q * t_s4[3];
		po_s5[0][2] <= qy_q * t_s4[2];
		po_s5[0][3] <= qz_q * t_s4[1];
		po_s5[1][0] <= qw_q * t_s4[1];
		po_s5[1][1] <= qx_q * t_s4[2];
		po_s5[1][2] <= qy_q * t_s4[3];
		po_s5[1][3] <= qz_q * t_s4[0];
		po_s5[2][0] <= qw_q * t_s4[2];
		po_s5[2][1] <= qx_q * t_s4[1];
		po_s5[2][2] <= qy_q * t_s4[0];
		po_s5[2][3] <= qz_q * t_s4[3];
		side_s5     <= side_s4;

		r_s6[0] <= NORM_W'(po_s5[0][0] + po_s5[0][1] + po_s5[0][2] - po_s5[0][3]);
		r_s6[1] <= NORM_W'(po_s5[1][0] - po_s5[1][1] + po_s5[1][2] + po_s5[1][3]);
		r_s6[2] <= NORM_W'(po_s5[2][0] + po_s5[2][1] - po_s5[2][2] + po_s5[2][3]);
		side_s6 <= side_s5;

		for (int i = 0; i < 3; i++) begin
			r_s7[i] <= r_s6[i];
		end
		side_s7 <= side7_c;
	end

	// Direction mode finishes here; its result rides in the center slot.
	always_comb begin
		side7_c = side_s6;
		if (!side_s6.about) begin
			for (int i = 0; i < 3; i++) begin
				side7_c.cen[i] = sat_coord(rnd_shr(64'(r_s6[i]), R_FRAC - COORD_FRAC));
			end
		end
	end

	qvr_norm u_norm2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.in_vec    (r_s7),
		.in_side   (side_s7),
		.out_valid (n2_v),
		.out_res   (n2_res),
		.out_side  (n2_side)
	);

	// Offset = |u2| * length, scaled back by the first normalizer's shift.
	assign shr_c = SHIFT_W'(UNIT_FRAC) - side_s8.sh;

	always_ff @(posedge clk) begin
		logic [MAG_W-1:0] mag;
		for (int i = 0; i < 3; i++) begin
			mag = n2_res.u[i][UNIT_W-1] ? MAG_W'(-$signed(n2_res.u[i]))
				: MAG_W'(n2_res.u[i]);
			prod_s8[i] <= mag * n2_side.len;
			neg_s8[i]  <= n2_res.u[i][UNIT_W-1];
		end
		nz_s8   <= n2_res.nz;
		side_s8 <= n2_side;

		for (int i = 0; i < 3; i++) begin
			off_s9[i] <= (64'(prod_s8[i]) + (64'd1 << (shr_c - 1'b1))) >> shr_c;
		end
		neg_s9  <= neg_s8;
		nz_s9   <= nz_s8;
		side_s9 <= side_s8;

		for (int i = 0; i < 3; i++) begin
			if (!side_s9.about || !nz_s9) begin
				res_s10[i] <= side_s9.cen[i];
			end else begin
				res_s10[i] <= sat_coord(64'($signed(side_s9.cen[i]))
					- (neg_s9[i] ? -$signed(off_s9[i]) : $signed(off_s9[i])));
			end
		end
	end

	assign done  = v_s10;
	assign res_x = res_s10[0];
	assign res_y = res_s10[1];
	assign res_z = res_s10[2];

	// Checks.
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##PIPE_LAT done)
		else $error("request produced no result");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, PIPE_LAT))
		else $error("result without a request");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !about_center && (vec_x == '0) && (vec_y == '0) && (vec_z == '0)
		|-> ##PIPE_LAT ((res_x == '0) && (res_y == '0) && (res_z == '0)))
		else $error("zero direction gave a nonzero result");

endmodule

### dv/tb_quaternion_vector_rotate.sv
// ---------------------------------------------------------------------------
// tb_quaternion_vector_rotate: self-checking bench for the vector rotator.
// Runs direction and about-center requests through several quaternion
// settings. A fixed-point predictor computes each result when its request
// is taken, and the monitor checks results in order against those values.
// ---------------------------------------------------------------------------
module tb_quaternion_vector_rotate;
	timeunit 1ns;
	timeprecision 1ps;
	import qvr_pkg::*;

	typedef longint trip_t [3];
	typedef longint quad_t [4];

	typedef struct {
		coord_t vx, vy, vz, cx, cy, cz;
		logic   about;
	} rot_req_t;

	typedef struct {
		coord_t x, y, z;
	} rot_res_t;

	localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	coord_t vec_x = '0, vec_y = '0, vec_z = '0;
	coord_t center_x = '0, center_y = '0, center_z = '0;
	logic   about_center = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   [1:0] cfg_index = REG_QUAT_X;
	quat_t  cfg_data = '0;
	logic   busy, done, cfg_ready;
	coord_t res_x, res_y, res_z;

	// Local copy of the quaternion registers, updated on each accepted write.
	quat_t  q_reg [4];

	rot_req_t pending_req_q [$];
	rot_res_t rotated_q [$];
	rot_req_t cur_req;
	int       errors = 0;
	int       sent = 0;

	quaternion_vector_rotate i_dut (
		.clk, .arst_n, .start, .busy, .vec_x, .vec_y, .vec_z,
		.center_x, .center_y, .center_z, .about_center,
		.done, .res_x, .res_y, .res_z,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Fixed-point predictor.
	// ------------------------------------------------------------------
	function automatic longint shr_round(input longint v, input int n);
		bit [63:0] mag;
		mag = (v < 0) ? 64'(-v) : 64'(v);
		mag = (mag + (64'd1 << (n - 1))) >> n;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI) begin
			return COORD_HI;
		end
		if (v < COORD_LO) begin
			return COORD_LO;
		end
		return v;
	endfunction

	function automatic bit [63:0] int_sqrt(input bit [63:0] n);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Scales v to a Q1.30 unit vector; returns 0 for the zero vector.
	function automatic bit to_unit(input trip_t v, output trip_t u,
		output bit [63:0] len, output int s);
		bit [63:0] m [3];
		bit [63:0] a [3];
		bit [63:0] mx, sum, qt, lim;
		lim = 64'd1 << UNIT_FRAC;
		mx = 0;
		sum = 0;
		s = 0;
		len = 0;
		u = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			return 1'b0;
		end
		while ((mx >> s) >= (64'd1 << 31)) s++;
		while (s <= 0 && (mx << (-s)) < lim) s--;
		for (int i = 0; i < 3; i++) begin
			a[i] = (s >= 0) ? (m[i] >> s) : (m[i] << (-s));
			sum += a[i] * a[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			qt = ((a[i] << UNIT_FRAC) + (len >> 1)) / len;
			if (qt > lim) qt = lim;
			u[i] = (v[i] < 0) ? -longint'(qt) : longint'(qt);
		end
		return 1'b1;
	endfunction

	// Hamilton product, components in x, y, z, w order.
	function automatic quad_t hamilton(input quad_t a, input quad_t b);
		quad_t o;
		o[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
		o[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
		o[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
		o[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
		return o;
	endfunction

	// q * (u * conj(q)) with the middle term rounded to Q.30; result Q.44.
	function automatic trip_t spin(input trip_t u);
		quad_t q, qc, uq, t;
		trip_t r;
		q  = '{longint'(q_reg[0]), longint'(q_reg[1]), longint'(q_reg[2]),
			longint'(q_reg[3])};
		qc = '{-q[0], -q[1], -q[2], q[3]};
		uq = '{u[0], u[1], u[2], 0};
		t = hamilton(uq, qc);
		for (int i = 0; i < 4; i++) t[i] = shr_round(t[i], QUAT_FRAC);
		t = hamilton(q, t);
		r = '{t[0], t[1], t[2]};
		return r;
	endfunction

	function automatic rot_res_t predict_rotation(input rot_req_t rq);
		trip_t p, c, d, u, u2, r, o;
		bit [63:0] len, len2, mag, off;
		int s, s2, sh;
		rot_res_t res;
		p = '{longint'(rq.vx), longint'(rq.vy), longint'(rq.vz)};
		c = '{longint'(rq.cx), longint'(rq.cy), longint'(rq.cz)};
		if (!rq.about) begin
			o = '{0, 0, 0};
			if (to_unit(p, u, len, s)) begin
				r = spin(u);
				for (int i = 0; i < 3; i++)
					o[i] = clamp_coord(shr_round(r[i], R_FRAC - COORD_FRAC));
			end
		end else begin
			for (int i = 0; i < 3; i++) d[i] = c[i] - p[i];
			o = c;
			if (to_unit(d, u, len, s)) begin
				r = spin(u);
				if (to_unit(r, u2, len2, s2)) begin
					sh = UNIT_FRAC - s;
					for (int i = 0; i < 3; i++) begin
						mag = (u2[i] < 0) ? 64'(-u2[i]) : 64'(u2[i]);
						off = (mag * len + (64'd1 << (sh - 1))) >> sh;
						o[i] = (u2[i] < 0) ? c[i] + longint'(off) : c[i] - longint'(off);
					end
				end
			end
			for (int i = 0; i < 3; i++) o[i] = clamp_coord(o[i]);
		end
		res.x = coord_t'(o[0]);
		res.y = coord_t'(o[1]);
		res.z = coord_t'(o[2]);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: predicts each taken request, then loads the next one.
	// A calm stretch of requests is sent without gaps.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				rotated_q.push_back(predict_rotation(cur_req));
				sent++;
			end
			if ((start && busy) ) begin
				// Hold the current request until it is taken.
			end else if (pending_req_q.size() > 0 &&
				((sent > 700 && sent < 1000) || $urandom_range(99) >= 34)) begin
				cur_req = pending_req_q.pop_front();
				start <= 1'b1;
				vec_x <= cur_req.vx;
				vec_y <= cur_req.vy;
				vec_z <= cur_req.vz;
				center_x <= cur_req.cx;
				center_y <= cur_req.cy;
				center_z <= cur_req.cz;
				about_center <= cur_req.about;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor: every strobe must match the oldest prediction.
	always @(posedge clk) begin
		rot_res_t exp_res;
		if (arst_n && done) begin
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected result %h %h %h", $time, res_x, res_y, res_z);
				errors++;
			end else begin
				exp_res = rotated_q.pop_front();
				if (res_x !== exp_res.x) begin
					$display("%0t: res_x expected %h actual %h", $time, exp_res.x, res_x);
					errors++;
				end
				if (res_y !== exp_res.y) begin
					$display("%0t: res_y expected %h actual %h", $time, exp_res.y, res_y);
					errors++;
				end
				if (res_z !== exp_res.z) begin
					$display("%0t: res_z expected %h actual %h", $time, exp_res.z, res_z);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic write_quat(input logic [1:0] idx, input quat_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		q_reg[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_quat(input quat_t x, input quat_t y, input quat_t z, input quat_t w);
		write_quat(REG_QUAT_X, x);
		write_quat(REG_QUAT_Y, y);
		write_quat(REG_QUAT_Z, z);
		write_quat(REG_QUAT_W, w);
	endtask

	task automatic drain();
		while (pending_req_q.size() > 0 || start || rotated_q.size() > 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(8191)) - 4096);
			2: return $urandom_range(1) ? coord_t'(COORD_HI) : coord_t'(COORD_LO);
			3: return coord_t'($signed($urandom_range(2000000)) - 1000000);
			default: return coord_t'($signed($urandom_range(31)) - 16);
		endcase
	endfunction

	task automatic push_req(input coord_t vx, input coord_t vy, input coord_t vz,
		input coord_t cx, input coord_t cy, input coord_t cz, input logic about);
		rot_req_t rq;
		rq = '{vx, vy, vz, cx, cy, cz, about};
		pending_req_q.push_back(rq);
	endtask

	// Random requests; about-center points are often near or on the center.
	task automatic push_random(input int n);
		coord_t cx, cy, cz;
		for (int k = 0; k < n; k++) begin
			cx = rand_coord();
			cy = rand_coord();
			cz = rand_coord();
			case ($urandom_range(7))
				0: push_req(cx, cy, cz, cx, cy, cz, 1'($urandom_range(1)));
				1: push_req(cx + coord_t'($signed($urandom_range(15)) - 8), cy, cz,
					cx, cy, cz, 1'b1);
				2: push_req('0, '0, '0, cx, cy, cz, 1'($urandom_range(1)));
				default: push_req(rand_coord(), rand_coord(), rand_coord(),
					cx, cy, cz, 1'($urandom_range(1)));
			endcase
		end
	endtask

	task automatic push_directed();
		coord_t hi, lo;
		hi = coord_t'(COORD_HI);
		lo = coord_t'(COORD_LO);
		// Zero direction, and a point sitting on the center.
		push_req('0, '0, '0, hi, lo, hi, 1'b0);
		push_req(lo, hi, 24'sd5, lo, hi, 24'sd5, 1'b1);
		// Field extremes in both modes.
		push_req(hi, hi, hi, '0, '0, '0, 1'b0);
		push_req(lo, lo, lo, '0, '0, '0, 1'b0);
		push_req(hi, lo, '0, '0, '0, '0, 1'b0);
		push_req(24'sd1, '0, '0, '0, '0, '0, 1'b0);
		push_req('0, -24'sd1, '0, '0, '0, '0, 1'b0);
		push_req('0, '0, 24'sd4096, '0, '0, '0, 1'b0);
		push_req(lo, lo, lo, hi, hi, hi, 1'b1);
		push_req(hi, hi, hi, lo, lo, lo, 1'b1);
		push_req(24'sd4096, '0, '0, '0, '0, '0, 1'b1);
		push_req('0, '0, '0, '0, 24'sd1, '0, 1'b1);
		push_req(hi, '0, lo, lo, '0, hi, 1'b1);
		push_req(24'sd3, -24'sd7, 24'sd11, hi, hi, lo, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Test sequence: several quaternion settings, each with its own requests.
	// ------------------------------------------------------------------
	initial begin
		q_reg = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Identity rotation out of reset.
		push_directed();
		push_random(200);
		drain();

		// 90 degrees about z, then an arbitrary unit quaternion.
		set_quat(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
		push_directed();
		push_random(250);
		drain();
		set_quat(16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192);
		push_random(250);
		drain();

		// Zero quaternion.
		set_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		push_directed();
		push_random(150);
		drain();

		// Register extremes: non-unit quaternions.
		set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		push_directed();
		push_random(200);
		drain();
		set_quat(16'sh7fff, 16'h8000, 16'sh7fff, 16'h8000);
		push_random(200);
		drain();

		// Random quaternions.
		for (int k = 0; k < 4; k++) begin
			set_quat(quat_t'($urandom), quat_t'($urandom), quat_t'($urandom),
				quat_t'($urandom));
			push_random(120);
			drain();
		end

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#3ms;
		$display("simulation failed");
		$finish;
	end

endmodule
